// ----- sv/gta_pkg.sv -----
// Package with the shared codes and fixed widths of the gated track association block.
`default_nettype none
package gta_pkg;

  // Command codes of an input word.
  localparam logic CMD_POINT = 1'b0;
  localparam logic CMD_EOF   = 1'b1;

  // Kind codes of a result word.
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  // Fixed field widths.
  localparam int POS_W   = 16;  // Q12.4 position
  localparam int PRED_W  = 18;  // point minus motion, signed
  localparam int DIFF_W  = 18;  // stored position minus prediction, signed
  localparam int SQ_W    = 34;  // one squared difference, unsigned
  localparam int D2_W    = 35;  // sum of two squares, unsigned
  localparam int THR_W   = 32;
  localparam int CNT_OUT_W   = 9;
  localparam int INDEX_OUT_W = 8;

  localparam logic [THR_W-1:0] THR_RESET = 32'd1024;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic signed [PRED_W-1:0] pred_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage
`default_nettype wire

// ----- sv/gated_track_association.sv -----
// Top level of the gated greedy track association block.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid / in_ready    | command, point_x, point_y, motion_x, motion_y
//   output   | out_valid / out_ready  | result_kind, matched, tracks_extended,
//            |                        | first_extended, new_track_created,
//            |                        | table_full, tracks_in_use
//   config   | cfg_write              | cfg_data (gate_threshold)
//
// A point word is matched by reading the track memory at one address per cycle over
// the N tracks held, and each entry goes through a three-stage distance pipeline.
// Tracks already updated this frame drop out at the first stage, so the pipeline
// drains early when they lie at the end of the table. An end-of-frame word makes a
// pass that clears the updated flag of every held track.
// The block works on one word at a time; in_ready is high only when it is idle,
// and a finished result waits in its own stage while the output is stalled, so a
// new word is accepted as soon as the result has moved into the output register.
// Reset is synchronous and active high; it empties the track table at once, since
// only entries below the track count are ever read.
`default_nettype none
module gated_track_association #(
  parameter int MAX_TRACKS = 256
) (
  input  wire                        clk,
  input  wire                        rst,
  // Configuration.
  input  wire                        cfg_write,
  input  wire [31:0]                 cfg_data,
  // Input channel.
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire                        command,
  input  wire [15:0]                 point_x,
  input  wire [15:0]                 point_y,
  input  wire signed [15:0]          motion_x,
  input  wire signed [15:0]          motion_y,
  // Output channel.
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       result_kind,
  output logic                       matched,
  output logic [8:0]                 tracks_extended,
  output logic [7:0]                 first_extended,
  output logic                       new_track_created,
  output logic                       table_full,
  output logic [8:0]                 tracks_in_use
);

  // Index width addresses the table; count width also holds MAX_TRACKS itself.
  localparam int AW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_TRACKS);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MATCH  = 2'd1;
  localparam logic [1:0] ST_CLEAR  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;

  logic [gta_pkg::THR_W-1:0] gate_threshold;

  // Track memories: last position as {y, x} and the per-frame updated flag.
  logic [2*gta_pkg::POS_W-1:0] pos_mem [MAX_TRACKS];
  logic                        flag_mem [MAX_TRACKS];
  logic [2*gta_pkg::POS_W-1:0] pos_rdata;
  logic                        flag_rdata;

  logic                        pos_we;
  logic [AW-1:0]               pos_waddr;
  logic                        flag_we;
  logic [AW-1:0]               flag_waddr;
  logic                        flag_wdata;

  // Held track count and the scan counter shared by matching and clearing.
  logic [CW-1:0] track_count;
  logic [CW-1:0] scan;
  logic          scan_active;

  // The word being worked on.
  gta_pkg::pos_t  cur_x;
  gta_pkg::pos_t  cur_y;
  gta_pkg::pred_t pred_x;
  gta_pkg::pred_t pred_y;

  // Distance pipeline.
  logic                        s1_valid;
  logic [AW-1:0]               s1_addr;
  logic                        s2_valid;
  logic [AW-1:0]               s2_addr;
  gta_pkg::diff_t              s2_dx;
  gta_pkg::diff_t              s2_dy;
  logic                        s3_valid;
  logic [AW-1:0]               s3_addr;
  logic [gta_pkg::SQ_W-1:0]    s3_sqx;
  logic [gta_pkg::SQ_W-1:0]    s3_sqy;

  logic signed [gta_pkg::DIFF_W:0]     dx_wide;
  logic signed [gta_pkg::DIFF_W:0]     dy_wide;
  logic signed [2*gta_pkg::DIFF_W-1:0] sqx_full;
  logic signed [2*gta_pkg::DIFF_W-1:0] sqy_full;
  logic [gta_pkg::D2_W-1:0]            d2;
  logic                                hit;
  logic                                pipe_busy;

  // Working result of the current word.
  logic          res_kind;
  logic [CW-1:0] res_ext;
  logic [AW-1:0] res_first;
  logic          res_created;
  logic          res_full;

  // New track at the end of an unmatched point.
  logic          make_track;

  // The finished result moves into the output register in this cycle.
  logic          out_load;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_FINISH) && (!out_valid || out_ready);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_threshold <= gta_pkg::THR_RESET;
    end else if (cfg_write) begin
      gate_threshold <= cfg_data;
    end
  end

  // The scan issues one read per cycle over the held tracks.
  assign scan_active = ((state == ST_MATCH) || (state == ST_CLEAR)) && (scan < track_count);
  assign pipe_busy   = s1_valid || s2_valid || s3_valid;

  // Stage one: difference between the stored position and the prediction.
  // Both fit in the signed difference width, so the top bit is dropped.
  always_comb begin
    dx_wide = $signed({3'b000, pos_rdata[gta_pkg::POS_W-1:0]})
              - $signed({pred_x[gta_pkg::PRED_W-1], pred_x});
    dy_wide = $signed({3'b000, pos_rdata[2*gta_pkg::POS_W-1:gta_pkg::POS_W]})
              - $signed({pred_y[gta_pkg::PRED_W-1], pred_y});
  end

  // Stage two: one square per axis.
  assign sqx_full = s2_dx * s2_dx;
  assign sqy_full = s2_dy * s2_dy;

  // Stage three: exact sum and strict compare against the gate.
  assign d2  = {1'b0, s3_sqx} + {1'b0, s3_sqy};
  assign hit = s3_valid && (d2 < {{(gta_pkg::D2_W - gta_pkg::THR_W){1'b0}}, gate_threshold});

  // A point that matched nothing starts a track once the pipeline has drained.
  assign make_track = (state == ST_MATCH) && !scan_active && !pipe_busy
                      && (res_ext == '0) && (track_count < MAX_COUNT);

  // Write port selection. Hits and the new track never fall in the same cycle.
  always_comb begin
    pos_we     = 1'b0;
    pos_waddr  = s3_addr;
    flag_we    = 1'b0;
    flag_waddr = s3_addr;
    flag_wdata = 1'b1;
    if (hit) begin
      pos_we  = 1'b1;
      flag_we = 1'b1;
    end else if (make_track) begin
      pos_we     = 1'b1;
      pos_waddr  = track_count[AW-1:0];
      flag_we    = 1'b1;
      flag_waddr = track_count[AW-1:0];
    end else if ((state == ST_CLEAR) && scan_active) begin
      flag_we    = 1'b1;
      flag_waddr = scan[AW-1:0];
      flag_wdata = 1'b0;
    end
  end

  // Memories with a registered read port.
  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= {cur_y, cur_x};
    end
    pos_rdata <= pos_mem[scan[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
    flag_rdata <= flag_mem[scan[AW-1:0]];
  end

  // Pipeline registers. Tracks already extended this frame drop out at stage one.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= scan_active && (state == ST_MATCH);
      s2_valid <= s1_valid && !flag_rdata;
      s3_valid <= s2_valid;
    end
    s1_addr <= scan[AW-1:0];
    s2_addr <= s1_addr;
    s2_dx   <= dx_wide[gta_pkg::DIFF_W-1:0];
    s2_dy   <= dy_wide[gta_pkg::DIFF_W-1:0];
    s3_addr <= s2_addr;
    s3_sqx  <= sqx_full[gta_pkg::SQ_W-1:0];
    s3_sqy  <= sqy_full[gta_pkg::SQ_W-1:0];
  end

  // Sequencer, track count and working result.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      track_count <= '0;
      scan        <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            scan        <= '0;
            res_kind    <= command;
            res_ext     <= '0;
            res_first   <= '0;
            res_created <= 1'b0;
            res_full    <= 1'b0;
            cur_x       <= point_x;
            cur_y       <= point_y;
            pred_x      <= $signed({2'b00, point_x}) - $signed({{2{motion_x[15]}}, motion_x});
            pred_y      <= $signed({2'b00, point_y}) - $signed({{2{motion_y[15]}}, motion_y});
            state       <= (command == gta_pkg::CMD_EOF) ? ST_CLEAR : ST_MATCH;
          end
        end
        ST_MATCH: begin
          if (scan_active) begin
            scan <= scan + 1'b1;
          end
          if (hit) begin
            if (res_ext == '0) begin
              res_first <= s3_addr;
            end
            res_ext <= res_ext + 1'b1;
          end
          if (!scan_active && !pipe_busy) begin
            if (res_ext == '0) begin
              if (make_track) begin
                track_count <= track_count + 1'b1;
                res_created <= 1'b1;
              end else begin
                res_full <= 1'b1;
              end
            end
            state <= ST_FINISH;
          end
        end
        ST_CLEAR: begin
          if (scan_active) begin
            scan <= scan + 1'b1;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // The result moves out once the output register is free.
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Output register; counts wider than the result fields are masked.
  always_ff @(posedge clk) begin
    if (out_load) begin
      result_kind       <= res_kind;
      matched           <= (res_ext != '0);
      tracks_extended   <= gta_pkg::CNT_OUT_W'(res_ext);
      first_extended    <= gta_pkg::INDEX_OUT_W'(res_first);
      new_track_created <= res_created;
      table_full        <= res_full;
      tracks_in_use     <= gta_pkg::CNT_OUT_W'(track_count);
    end
  end

endmodule
`default_nettype wire

// ----- sv/gta_checker.sv -----
// Port-level checker for the gated track association block, with its bind.
`default_nettype none
module gta_checker (
  input wire       clk,
  input wire       rst,
  input wire       out_valid,
  input wire       out_ready,
  input wire       result_kind,
  input wire       matched,
  input wire [8:0] tracks_extended,
  input wire [7:0] first_extended,
  input wire       new_track_created,
  input wire       table_full,
  input wire [8:0] tracks_in_use
);

  // A stalled result word holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tracks_extended)
      && $stable(first_extended) && $stable(tracks_in_use) && $stable(result_kind))
    else $error("result word changed while stalled");

  // An end-of-frame result carries no match information.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == gta_pkg::KIND_EOF) |-> !matched && (tracks_extended == 9'd0)
      && (first_extended == 8'd0) && !new_track_created && !table_full)
    else $error("end-of-frame result carries point fields");

  // A point has exactly one outcome: matched, new track or dropped.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (result_kind == gta_pkg::KIND_POINT)
      |-> $onehot({matched, new_track_created, table_full}))
    else $error("point result without a single outcome");

  // A new track always occupies a slot, so the table cannot be empty afterwards.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && new_track_created |-> (tracks_in_use != 9'd0))
    else $error("new track reported with an empty table");

endmodule

bind gated_track_association gta_checker u_gta_checker (.*);
`default_nettype wire
